// ===== rtl/tsss_pkg.sv =====
package tsss_pkg;

   // Payload widths
   localparam int SAMPLE_W   = 10;
   localparam int HUND_W     = 14;
   localparam int DIGIT_W    = 4;
   localparam int DIGIT_EN_W = 4;
   localparam int SEG_W      = 7;
   localparam int POINT_W    = 2;

   // Sample scaling: hundredths = sample * 1375 >> 7
   localparam int SCALE_MUL_W = 11;
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 11'd1375;
   localparam int SCALE_SHIFT = 7;

   // Exact q / 10 for q below 2**14: (q * 6554) >> 16
   localparam int DIV10_MUL_W = 13;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;
   localparam int DIV10_SHIFT = 16;

   // Command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = HUND_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_SLOT      = 1'd1;

   localparam logic [HUND_W-1:0]  THRESHOLD_RESET  = 14'd3000;
   localparam logic [POINT_W-1:0] POINT_SLOT_RESET = 2'd1;

   typedef logic [HUND_W-1:0] hund_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      unique case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h18;
         4'd2:    s = 7'h6D;
         4'd3:    s = 7'h79;
         4'd4:    s = 7'h5A;
         4'd5:    s = 7'h73;
         4'd6:    s = 7'h77;
         4'd7:    s = 7'h09;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h7B;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/tsss_req_if.sv =====
interface tsss_req_if
   import tsss_pkg::*;
;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, input ready, output cmd, output sample);
   modport sink   (input valid, output ready, input cmd, input sample);
endinterface

// ===== rtl/tsss_rsp_if.sv =====
interface tsss_rsp_if
   import tsss_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [DIGIT_EN_W-1:0] digit_enables;
   logic [SEG_W-1:0]      segments;
   logic                  point_on;
   logic                  alarm;

   modport source (output valid, input ready, output digit_enables, output segments,
                   output point_on, output alarm);
   modport sink   (input valid, output ready, input digit_enables, input segments,
                   input point_on, input alarm);
endinterface

// ===== rtl/temperature_seven_segment_scanner.sv =====
// Channel  | Dir | Payload                                   | Beat
// req      | in  | cmd, sample                               | valid & ready
// rsp      | out | digit_enables, segments, point_on, alarm  | valid & ready
// csr      | in  | csr_index, csr_wdata                      | csr_we
//
// One result beat per request beat; each request beat reaches its response beat through
// the capture, scale, divide and encode registers, in that order.
// One beat per cycle sustained while rsp is ready.
// Synchronous reset loads the config defaults and clears scan slot, hundredths and valids.
// Each stage moves when the one after it is empty or moving, so bubbles
// collapse and a stalled rsp only backs up the stages that are full.
module temperature_seven_segment_scanner
   import tsss_pkg::*;
#(
   parameter int NUM_DIGITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   tsss_req_if.sink               req,
   tsss_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SlotW = $clog2(NUM_DIGITS);
   localparam int EnW   = (NUM_DIGITS > DIGIT_EN_W) ? NUM_DIGITS : DIGIT_EN_W;
   localparam int CmpW  = (SlotW > POINT_W) ? SlotW : POINT_W;
   localparam int ProdW = SAMPLE_W + SCALE_MUL_W;
   localparam int QProdW = HUND_W + DIV10_MUL_W;
   localparam logic [EnW-1:0]   LaneMask = EnW'((64'd1 << NUM_DIGITS) - 64'd1);
   localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_DIGITS - 1);

   // config
   hund_type             thresh_ff;
   logic [POINT_W-1:0]   point_ff;

   // scan slot at the request side
   logic [SlotW-1:0]     slot_ff;

   // stage 1: captured request
   logic                 s1_valid_ff;
   logic                 s1_cmd_ff;
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   logic [SlotW-1:0]     s1_slot_ff;

   // stage 2: hundredths state, current as of the stage 2 beat
   logic                 s2_valid_ff;
   logic [SlotW-1:0]     s2_slot_ff;
   hund_type             hund_ff;
   hund_type             hund_in;
   logic [ProdW-1:0]     scale_prod;

   // stage 3: quotient for the slot's position
   logic                 s3_valid_ff;
   logic [SlotW-1:0]     s3_slot_ff;
   hund_type             s3_quot_ff;
   hund_type             s3_quot_in;
   logic                 s3_alarm_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [DIGIT_EN_W-1:0] rsp_en_ff;
   logic [DIGIT_EN_W-1:0] rsp_en_in;
   logic [SEG_W-1:0]      rsp_seg_ff;
   logic [SEG_W-1:0]      rsp_seg_in;
   logic                  rsp_point_ff;
   logic                  rsp_point_in;
   logic                  rsp_alarm_ff;

   logic adv_out, adv3, adv2, adv1;
   logic req_beat;

   assign adv_out  = !rsp_valid_ff || rsp.ready;
   assign adv3     = !s3_valid_ff || adv_out;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign req.ready = adv1;
   assign req_beat = req.valid && adv1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
         point_ff  <= POINT_SLOT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALARM_THRESHOLD: thresh_ff <= csr_wdata;
            CSR_POINT_SLOT:      point_ff  <= csr_wdata[POINT_W-1:0];
            default: ;
         endcase
      end
   end

   // slot is assigned at acceptance; a tick advances it after its own beat
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (req_beat && req.cmd == CMD_TICK) begin
         slot_ff <= (slot_ff == LastSlot) ? '0 : slot_ff + SlotW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_cmd_ff    <= req.cmd;
         s1_sample_ff <= req.sample;
         s1_slot_ff   <= slot_ff;
      end
   end

   // scale to hundredths; the product never exceeds 14 bits after the shift
   assign scale_prod = ProdW'(s1_sample_ff) * ProdW'(SCALE_MUL);
   assign hund_in    = HUND_W'(scale_prod >> SCALE_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         hund_ff     <= '0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && s1_cmd_ff == CMD_SAMPLE) begin
            hund_ff <= hund_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_slot_ff <= s1_slot_ff;
      end
   end

   tsss_digit_select #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_digit_select (
      .hund (hund_ff),
      .slot (s2_slot_ff),
      .quot (s3_quot_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_slot_ff  <= s2_slot_ff;
         s3_quot_ff  <= s3_quot_in;
         s3_alarm_ff <= hund_ff > thresh_ff;
      end
   end

   // last digit of the quotient, segment lookup, enables and point
   always_comb begin
      logic [QProdW-1:0]  q_prod;
      hund_type           q_div10;
      hund_type           q_rem;
      logic [EnW-1:0]     en_full;

      q_prod       = QProdW'(s3_quot_ff) * QProdW'(DIV10_MUL);
      q_div10      = HUND_W'(q_prod >> DIV10_SHIFT);
      q_rem        = s3_quot_ff - ((q_div10 << 3) + (q_div10 << 1));
      rsp_seg_in   = seg_of(q_rem[DIGIT_W-1:0]);
      en_full      = ~(EnW'(1) << s3_slot_ff) & LaneMask;
      rsp_en_in    = en_full[DIGIT_EN_W-1:0];
      rsp_point_in = CmpW'(s3_slot_ff) == CmpW'(point_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_en_ff    <= rsp_en_in;
         rsp_seg_ff   <= rsp_seg_in;
         rsp_point_ff <= rsp_point_in;
         rsp_alarm_ff <= s3_alarm_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.digit_enables = rsp_en_ff;
   assign rsp.segments      = rsp_seg_ff;
   assign rsp.point_on      = rsp_point_ff;
   assign rsp.alarm         = rsp_alarm_ff;

endmodule

// ===== rtl/tsss_digit_select.sv =====
// Picks hundredths / 10**p for the slot's digit position p = NUM_DIGITS-1-slot.
// Each power of ten is one constant reciprocal multiply, exact over 14 bits.
module tsss_digit_select
   import tsss_pkg::*;
#(
   parameter int NUM_DIGITS = 4
) (
   input  hund_type                          hund,
   input  logic [$clog2(NUM_DIGITS)-1:0]     slot,
   output hund_type                          quot
);

   localparam int SlotW = $clog2(NUM_DIGITS);
   localparam int ProdW = HUND_W + HUND_W + 1;
   localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_DIGITS - 1);

   hund_type         q_all [NUM_DIGITS];
   logic [SlotW-1:0] pos;

   for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_pow
      localparam longint unsigned Div   = 64'd10 ** p;
      localparam int              Shift = HUND_W + $clog2(Div);
      localparam longint unsigned Mult  = ((64'd1 << Shift) + Div - 64'd1) / Div;

      logic [ProdW-1:0] prod;

      assign prod     = ProdW'(hund) * ProdW'(Mult);
      assign q_all[p] = HUND_W'(prod >> Shift);
   end

   assign pos  = LastSlot - slot;
   assign quot = q_all[pos];

endmodule

// ===== dv/temperature_seven_segment_scanner_tb.sv =====
`timescale 1ns / 1ps

module temperature_seven_segment_scanner_tb
   import tsss_pkg::*;
;

   localparam int LATENCY     = 4;
   localparam int DRAIN_LIMIT = 5000;

   typedef struct packed {
      logic [DIGIT_EN_W-1:0] enables;
      logic [SEG_W-1:0]      segs;
      logic                  point;
      logic                  alarm;
   } drive_word_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tsss_req_if req_ch ();
   tsss_rsp_if rsp_ch ();

   temperature_seven_segment_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // display shadow state
   logic [HUND_W-1:0]  shadow_threshold;
   logic [POINT_W-1:0] shadow_point;
   logic [DIGIT_W-1:0] shadow_digits [4];
   logic [HUND_W-1:0]  shadow_hund;
   logic [1:0]         shadow_slot;

   drive_word_type pending_words [$];
   drive_word_type head_word;
   int             errors = 0;
   int             req_idle_odds = 0;
   int             rsp_idle_odds = 0;
   int             rsp_stall_left = 0;

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      case (d)
         4'd0:    return 7'h3F;
         4'd1:    return 7'h18;
         4'd2:    return 7'h6D;
         4'd3:    return 7'h79;
         4'd4:    return 7'h5A;
         4'd5:    return 7'h73;
         4'd6:    return 7'h77;
         4'd7:    return 7'h09;
         4'd8:    return 7'h7F;
         4'd9:    return 7'h7B;
         default: return 7'h00;
      endcase
   endfunction

   function automatic void reset_shadow();
      shadow_threshold = THRESHOLD_RESET;
      shadow_point     = POINT_SLOT_RESET;
      foreach (shadow_digits[k]) shadow_digits[k] = '0;
      shadow_hund = '0;
      shadow_slot = '0;
   endfunction

   // sample updates the store before the word; tick advances the slot after it
   function automatic drive_word_type next_drive_word(input logic cmd,
                                                      input logic [SAMPLE_W-1:0] s);
      drive_word_type w;
      int unsigned    scaled;
      if (cmd == CMD_SAMPLE) begin
         scaled = s;
         scaled = (scaled * 1375) >> 7;
         if (scaled > 16383) scaled = 16383;
         shadow_hund = scaled[HUND_W-1:0];
         for (int k = 3; k >= 0; k--) begin
            shadow_digits[k] = DIGIT_W'(scaled % 10);
            scaled = scaled / 10;
         end
      end
      w.enables = ~(DIGIT_EN_W'(1) << shadow_slot);
      w.segs    = glyph(shadow_digits[shadow_slot]);
      w.point   = (shadow_slot == shadow_point);
      w.alarm   = (shadow_hund > shadow_threshold);
      if (cmd == CMD_TICK) shadow_slot = shadow_slot + 2'd1;
      return w;
   endfunction

   task automatic send_beat(input logic cmd, input logic [SAMPLE_W-1:0] s);
      if (req_idle_odds != 0 && $urandom_range(1, req_idle_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.cmd    <= cmd;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      pending_words.push_back(next_drive_word(cmd, s));
   endtask

   task automatic send_tick();
      send_beat(CMD_TICK, SAMPLE_W'($urandom));
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_words.size() != 0) begin
         report($sformatf("%0d drive words never arrived", pending_words.size()));
         pending_words.delete();
      end
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ALARM_THRESHOLD) shadow_threshold = data[HUND_W-1:0];
      else if (idx == CSR_POINT_SLOT) shadow_point = data[POINT_W-1:0];
   endtask

   // result side: random back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_idle_odds != 0 && $urandom_range(1, rsp_idle_odds) == 1) begin
            rsp_stall_left = $urandom_range(1, 12) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            report("drive word beat with nothing pending");
         end else begin
            head_word = pending_words.pop_front();
            if (rsp_ch.digit_enables !== head_word.enables)
               report($sformatf("digit_enables got %h want %h",
                                rsp_ch.digit_enables, head_word.enables));
            if (rsp_ch.segments !== head_word.segs)
               report($sformatf("segments got %h want %h",
                                rsp_ch.segments, head_word.segs));
            if (rsp_ch.point_on !== head_word.point)
               report($sformatf("point_on got %b want %b",
                                rsp_ch.point_on, head_word.point));
            if (rsp_ch.alarm !== head_word.alarm)
               report($sformatf("alarm got %b want %b",
                                rsp_ch.alarm, head_word.alarm));
         end
      end
   end

   // reset digits, slot wrap, reset point slot
   task automatic test_reset_scan();
      repeat (5) send_tick();
   endtask

   // zero, full scale (leading digit wraps to 0), alternating bit patterns
   task automatic test_sample_extremes();
      send_beat(CMD_SAMPLE, '0);
      send_tick();
      send_beat(CMD_SAMPLE, 10'h3FF);
      repeat (4) send_tick();
      send_beat(CMD_SAMPLE, 10'h2AA);
      send_beat(CMD_SAMPLE, 10'h155);
   endtask

   // sample 280 scales to 3007: alarm is strictly-greater
   task automatic test_alarm_edge();
      drain();
      write_reg(CSR_ALARM_THRESHOLD, 14'd3007);
      send_beat(CMD_SAMPLE, 10'd280);
      drain();
      write_reg(CSR_ALARM_THRESHOLD, 14'd3006);
      send_beat(CMD_SAMPLE, 10'd280);
      drain();
      write_reg(CSR_ALARM_THRESHOLD, 14'd0);
      send_beat(CMD_SAMPLE, 10'd0);
      send_beat(CMD_SAMPLE, 10'd1);
      drain();
      write_reg(CSR_ALARM_THRESHOLD, 14'h3FFF);
      send_beat(CMD_SAMPLE, 10'h3FF);
   endtask

   // upper data bits are don't-care for the point slot register
   task automatic test_point_slots();
      for (int p = 0; p < 4; p++) begin
         drain();
         write_reg(CSR_POINT_SLOT, {12'($urandom), 2'(p)});
         send_tick();
      end
   endtask

   task automatic test_random_traffic();
      logic [SAMPLE_W-1:0] s;
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_ALARM_THRESHOLD, 14'd0);
            1:       write_reg(CSR_ALARM_THRESHOLD, 14'h3FFF);
            default: write_reg(CSR_ALARM_THRESHOLD, 14'($urandom_range(0, 11000)));
         endcase
         write_reg(CSR_POINT_SLOT, 14'($urandom));
         case (phase)
            0:       begin req_idle_odds = 3; rsp_idle_odds = 4; end
            1:       begin req_idle_odds = 0; rsp_idle_odds = 2; end
            2:       begin req_idle_odds = 6; rsp_idle_odds = 0; end
            3:       begin req_idle_odds = 2; rsp_idle_odds = 3; end
            default: begin req_idle_odds = 0; rsp_idle_odds = 0; end
         endcase
         repeat (360) begin
            case ($urandom_range(0, 19))
               0:       s = '0;
               1:       s = 10'h3FF;
               default: s = SAMPLE_W'($urandom);
            endcase
            if ($urandom_range(0, 9) < 4) send_beat(CMD_SAMPLE, s);
            else send_tick();
         end
      end
   endtask

   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_SAMPLE;
      req_ch.sample <= '0;
      reset_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_scan();
      test_sample_extremes();
      test_alarm_edge();
      test_point_slots();
      test_random_traffic();
      drain();

      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
